// ===== rtl/i64d_pkg.sv =====
// Shared constants and types for the 64-bit integer divider.
// No dependencies; every other file of the divider uses this package.
package i64d_pkg;

  localparam int unsigned DATA_WIDTH = 64;

  // Division mode codes carried on the op field
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // Control bits travelling alongside each operand pair through the chain
  typedef struct packed {
    logic valid;
    logic div_zero;
    logic q_neg;
    logic r_neg;
  } ctl_t;

endpackage

// ===== rtl/i64d_in_if.sv =====
// Operand channel of the divider: valid/ready handshake plus payload.
// Depends on i64d_pkg for the default width.
interface i64d_in_if #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;
  logic                  op;

  modport source (output valid, output dividend, output divisor, output op, input ready);
  modport sink   (input valid, input dividend, input divisor, input op, output ready);
endinterface

// ===== rtl/i64d_out_if.sv =====
// Result channel of the divider: valid/ready handshake plus payload.
// Depends on i64d_pkg for the default width.
interface i64d_out_if #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] quotient;
  logic [DATA_WIDTH-1:0] remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/i64d_pre.sv =====
// Entry stage: takes operand magnitudes in signed mode and seeds the cell chain.
// Depends on i64d_pkg.
module i64d_pre #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  input  logic                  op,
  input  logic                  dn_ready,
  output i64d_pkg::ctl_t        ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] dvs
);

  logic                  n_neg;
  logic                  d_neg;
  logic [DATA_WIDTH-1:0] n_mag;
  logic [DATA_WIDTH-1:0] d_mag;

  assign n_neg = (op == i64d_pkg::OP_SIGNED) && dividend[DATA_WIDTH-1];
  assign d_neg = (op == i64d_pkg::OP_SIGNED) && divisor[DATA_WIDTH-1];
  assign n_mag = n_neg ? (~dividend + 1'b1) : dividend;
  assign d_mag = d_neg ? (~divisor + 1'b1) : divisor;

  assign up_ready = !ctl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (up_ready) begin
      ctl.valid    <= up_valid;
      ctl.div_zero <= (divisor == '0);
      ctl.q_neg    <= n_neg ^ d_neg;
      ctl.r_neg    <= n_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem <= '0;
      nq  <= n_mag;
      dvs <= d_mag;
    end
  end

endmodule

// ===== rtl/i64d_cell.sv =====
// One restoring division step: shift in the next dividend bit, trial subtract.
// Depends on i64d_pkg.
module i64d_cell #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  i64d_pkg::ctl_t        up_ctl,
  input  logic [DATA_WIDTH-1:0] up_rem,
  input  logic [DATA_WIDTH-1:0] up_nq,
  input  logic [DATA_WIDTH-1:0] up_dvs,
  output logic                  up_ready,
  input  logic                  dn_ready,
  output i64d_pkg::ctl_t        ctl,
  output logic [DATA_WIDTH-1:0] rem,
  output logic [DATA_WIDTH-1:0] nq,
  output logic [DATA_WIDTH-1:0] dvs
);

  // nq holds the unused dividend bits at the top and quotient bits at the bottom
  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] diff;
  logic                take;

  assign trial = {up_rem, up_nq[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, up_dvs};
  assign take  = !up_ctl.div_zero && (trial >= {1'b0, up_dvs});

  assign up_ready = !ctl.valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (up_ready) begin
      ctl <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      rem <= take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      nq  <= {up_nq[DATA_WIDTH-2:0], take};
      dvs <= up_dvs;
    end
  end

endmodule

// ===== rtl/i64d_post.sv =====
// Exit stage: applies result signs and holds the result for the output channel.
// Depends on i64d_pkg.
module i64d_post #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  i64d_pkg::ctl_t        up_ctl,
  input  logic [DATA_WIDTH-1:0] up_rem,
  input  logic [DATA_WIDTH-1:0] up_nq,
  output logic                  up_ready,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_ctl.valid) begin
      quotient  <= up_ctl.q_neg ? (~up_nq + 1'b1) : up_nq;
      remainder <= up_ctl.r_neg ? (~up_rem + 1'b1) : up_rem;
    end
  end

endmodule

// ===== rtl/int64_divider.sv =====
// Pipelined restoring divider: entry stage, DATA_WIDTH step cells, exit stage.
// Throughput one transaction per cycle unless results stall; each cell does one quotient bit.
// A stalled result only holds the stages behind it that are full; bubbles still close up.
// Synchronous reset clears every stage valid bit; payload registers are not reset.
// Depends on i64d_pkg, i64d_in_if, i64d_out_if, i64d_pre, i64d_cell, i64d_post.
module int64_divider #(
  parameter int unsigned DATA_WIDTH = i64d_pkg::DATA_WIDTH
) (
  input logic       clk,
  input logic       rst,
  i64d_in_if.sink   operands,
  i64d_out_if.source results
);

  i64d_pkg::ctl_t        ctl   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] nq    [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] dvs   [DATA_WIDTH+1];
  logic                  rdy   [DATA_WIDTH+1];

  i64d_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
    .clk      (clk),
    .rst      (rst),
    .up_valid (operands.valid),
    .up_ready (operands.ready),
    .dividend (operands.dividend),
    .divisor  (operands.divisor),
    .op       (operands.op),
    .dn_ready (rdy[0]),
    .ctl      (ctl[0]),
    .rem      (rem[0]),
    .nq       (nq[0]),
    .dvs      (dvs[0])
  );

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    i64d_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_ctl   (ctl[k]),
      .up_rem   (rem[k]),
      .up_nq    (nq[k]),
      .up_dvs   (dvs[k]),
      .up_ready (rdy[k]),
      .dn_ready (rdy[k+1]),
      .ctl      (ctl[k+1]),
      .rem      (rem[k+1]),
      .nq       (nq[k+1]),
      .dvs      (dvs[k+1])
    );
  end

  i64d_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk       (clk),
    .rst       (rst),
    .up_ctl    (ctl[DATA_WIDTH]),
    .up_rem    (rem[DATA_WIDTH]),
    .up_nq     (nq[DATA_WIDTH]),
    .up_ready  (rdy[DATA_WIDTH]),
    .dn_valid  (results.valid),
    .dn_ready  (results.ready),
    .quotient  (results.quotient),
    .remainder (results.remainder)
  );

`ifndef SYNTHESIS
  // A free output lets the whole chain move, so operands must be taken
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    results.ready |-> operands.ready)
    else $error("operand channel stalled while result channel ready");

  // Divide by zero never sets a quotient bit
  a_div_zero_quo: assert property (@(posedge clk) disable iff (rst)
    (ctl[DATA_WIDTH].valid && ctl[DATA_WIDTH].div_zero) |-> (nq[DATA_WIDTH] == '0))
    else $error("quotient bits set on division by zero");

  // Finished remainder magnitude is below the divisor magnitude
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl[DATA_WIDTH].valid && !ctl[DATA_WIDTH].div_zero) |->
      (rem[DATA_WIDTH] < dvs[DATA_WIDTH]))
    else $error("remainder not below divisor at end of chain");
`endif

endmodule
